@@ src/utf8_to_codepoint_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion macros for the decoder, clocked on i_clk; U2C_ASSERT is
// held off while i_rst_n is low. Defining ASSERT_OFF turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked only while the block is out of reset.
`define U2C_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("u2c assertion failed");

// Checked at every clock edge, reset included.
`define U2C_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("u2c assertion failed");

`else

`define U2C_ASSERT(label, prop)
`define U2C_ASSERT_ALWAYS(label, prop)

`endif

`endif

@@ src/u2c_pkg.sv @@
// ----------------------------------------------------------------------------
// u2c_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u2c_pkg;

    localparam int unsigned CP_W    = 21;
    localparam int unsigned WIDTH_W = 3;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    // Register map, by word index.
    localparam logic REG_OUT_WIDTH = 1'b0;

    // Configured storage widths that truncate the code point.
    localparam logic [WIDTH_W-1:0] OUT_W_BYTE = 3'd1;
    localparam logic [WIDTH_W-1:0] OUT_W_HALF = 3'd2;
    localparam logic [WIDTH_W-1:0] OUT_W_FULL = 3'd4;

    // Running storage widths.
    localparam logic [WIDTH_W-1:0] SEEN_ONE  = 3'd1;
    localparam logic [WIDTH_W-1:0] SEEN_TWO  = 3'd2;
    localparam logic [WIDTH_W-1:0] SEEN_FOUR = 3'd4;

    // Lead byte prefixes.
    localparam logic [2:0] LEAD2_PFX = 3'b110;
    localparam logic [3:0] LEAD3_PFX = 4'b1110;
    localparam logic [4:0] LEAD4_PFX = 5'b11110;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_END_MID  = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } t_in_req;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        t_status            status;
        logic [WIDTH_W-1:0] width_needed;
        logic               end_of_string;
    } t_out_req;

    typedef struct packed {
        logic [1:0]         bytes_remaining;
        logic [WIDTH_W-1:0] width_seen;
    } t_core_state;

endpackage

`default_nettype wire

@@ src/u2c_apb_regs.sv @@
// ----------------------------------------------------------------------------
// u2c_apb_regs
// APB register file holding the output width setting.
// ----------------------------------------------------------------------------
`default_nettype none

module u2c_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u2c_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [u2c_pkg::DATA_W-1:0]    pwdata,
    output logic      [u2c_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic      [u2c_pkg::WIDTH_W-1:0]   o_out_width
);

    logic [u2c_pkg::WIDTH_W-1:0] r_out_width;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == u2c_pkg::REG_OUT_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_width <= u2c_pkg::OUT_W_FULL;
        end else if (wr_en) begin
            r_out_width <= pwdata[u2c_pkg::WIDTH_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == u2c_pkg::REG_OUT_WIDTH) begin
            prdata = {{(u2c_pkg::DATA_W - u2c_pkg::WIDTH_W){1'b0}}, r_out_width};
        end
    end

    assign o_out_width = r_out_width;

endmodule

`default_nettype wire

@@ src/u2c_core.sv @@
// ----------------------------------------------------------------------------
// u2c_core
// Sequence state and single-step decode of one registered byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u2c_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire u2c_pkg::t_in_req              i_req,
    input  wire logic [u2c_pkg::WIDTH_W-1:0]   i_out_width,
    output logic                               o_emit,
    output u2c_pkg::t_out_req                  o_res,
    output u2c_pkg::t_core_state               o_state
);

    logic [u2c_pkg::CP_W-1:0]    r_partial, n_partial;
    logic [1:0]                  r_rem, n_rem;
    logic [u2c_pkg::WIDTH_W-1:0] r_width, n_width;
    logic [u2c_pkg::CP_W-1:0]    cp;
    logic [u2c_pkg::CP_W-1:0]    cp_kept;
    u2c_pkg::t_status            status;
    logic                        emit;
    logic [u2c_pkg::WIDTH_W-1:0] width_out;
    logic [7:0]                  b;

    assign b = i_req.in_byte;

    always_comb begin
        n_partial = r_partial;
        n_rem     = r_rem;
        n_width   = r_width;
        cp        = '0;
        status    = u2c_pkg::ST_OK;
        emit      = 1'b0;

        if (r_rem == 2'd0) begin
            priority if (b[7] == 1'b0) begin
                cp   = {{(u2c_pkg::CP_W - 8){1'b0}}, b};
                emit = 1'b1;
            end else if (b[7:5] == u2c_pkg::LEAD2_PFX) begin
                n_partial = {{(u2c_pkg::CP_W - 5){1'b0}}, b[4:0]};
                n_rem     = 2'd1;
                if (r_width < u2c_pkg::SEEN_TWO) begin
                    n_width = u2c_pkg::SEEN_TWO;
                end
            end else if (b[7:4] == u2c_pkg::LEAD3_PFX) begin
                n_partial = {{(u2c_pkg::CP_W - 4){1'b0}}, b[3:0]};
                n_rem     = 2'd2;
                if (r_width < u2c_pkg::SEEN_TWO) begin
                    n_width = u2c_pkg::SEEN_TWO;
                end
            end else if (b[7:3] == u2c_pkg::LEAD4_PFX) begin
                n_partial = {{(u2c_pkg::CP_W - 3){1'b0}}, b[2:0]};
                n_rem     = 2'd3;
                n_width   = u2c_pkg::SEEN_FOUR;
            end else begin
                status = u2c_pkg::ST_BAD_LEAD;
                emit   = 1'b1;
            end
        end else begin
            // Continuation byte: its prefix is not checked.
            n_partial = {r_partial[u2c_pkg::CP_W-7:0], b[5:0]};
            n_rem     = r_rem - 2'd1;
            if (n_rem == 2'd0) begin
                cp        = n_partial;
                n_partial = '0;
                emit      = 1'b1;
            end
        end

        if (i_req.is_last && (n_rem != 2'd0)) begin
            status = u2c_pkg::ST_END_MID;
            cp     = '0;
            emit   = 1'b1;
        end

        width_out = n_width;

        // The last byte returns the sequence state to its reset values.
        if (i_req.is_last) begin
            n_partial = '0;
            n_rem     = 2'd0;
            n_width   = u2c_pkg::SEEN_ONE;
        end
    end

    always_comb begin
        unique case (i_out_width)
            u2c_pkg::OUT_W_BYTE: cp_kept = {{(u2c_pkg::CP_W - 8){1'b0}}, cp[7:0]};
            u2c_pkg::OUT_W_HALF: cp_kept = {{(u2c_pkg::CP_W - 16){1'b0}}, cp[15:0]};
            default:             cp_kept = cp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_rem     <= 2'd0;
            r_width   <= u2c_pkg::SEEN_ONE;
        end else if (i_step) begin
            r_partial <= n_partial;
            r_rem     <= n_rem;
            r_width   <= n_width;
        end
    end

    assign o_emit                = emit;
    assign o_res.code_point      = (status == u2c_pkg::ST_OK) ? cp_kept : '0;
    assign o_res.status          = status;
    assign o_res.width_needed    = width_out;
    assign o_res.end_of_string   = i_req.is_last;
    assign o_state.bytes_remaining = r_rem;
    assign o_state.width_seen    = r_width;

endmodule

`default_nettype wire

@@ src/utf8_to_codepoint_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Streaming UTF-8 decoder. Bytes arrive one per request on the input channel,
// each with a flag that marks the last byte of a string. Every byte first
// lands in an input register; a short decode step then merges it into the
// sequence state and, when a result is due, loads the result register. The
// block takes one byte per cycle unless a full result register is not taken,
// and each result is offered from the result register as soon as the decode
// step has loaded it. The rate is set by the single decode step between the
// input register and the result register, which advances whenever the
// result register is empty or is being emptied. A one-byte character, a
// finished multi-byte sequence, a bad lead byte (status 1, byte dropped) and
// any last byte each give exactly one result; a lead or continuation byte
// that leaves more bytes expected gives none. A last byte that ends a string
// in the middle of a sequence gives status 2. The result carries the running
// storage width of the string (1, 2 or 4 bytes) and, after the last byte, the
// sequence state returns to its reset values. The code point is cut to 8 or
// 16 bits when the out_width_bytes register at address 0 holds 1 or 2, and
// kept whole otherwise; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_codepoint_decoder_assert.svh"

module utf8_to_codepoint_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Byte request channel.
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire u2c_pkg::t_in_req              i_in_req,
    // Code point request channel.
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output u2c_pkg::t_out_req                  o_out_req,
    // Configuration port.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [u2c_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [u2c_pkg::DATA_W-1:0]    pwdata,
    output logic      [u2c_pkg::DATA_W-1:0]    prdata,
    output logic                               pready
);

    // Input register: one byte request waiting for the decode step.
    logic              r_in_valid;
    u2c_pkg::t_in_req  r_in;

    // Result register: one code point request waiting to be taken.
    logic              r_out_valid;
    u2c_pkg::t_out_req r_out;

    logic                        step;
    logic                        emit;
    u2c_pkg::t_out_req           res;
    u2c_pkg::t_core_state        core_st;
    logic [u2c_pkg::WIDTH_W-1:0] out_width;

    // The decode step runs when a byte is held and the result register has
    // room for whatever it may produce this cycle.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    u2c_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_out_width (out_width)
    );

    u2c_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_req       (r_in),
        .i_out_width (out_width),
        .o_emit      (emit),
        .o_res       (res),
        .o_state     (core_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // The payload needs no reset; it only matters while its valid is set.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // A held byte is stalled only by a full result register that is not taken.
    `U2C_ASSERT(a_stall_from_output, r_in_valid && !o_in_ready |-> r_out_valid && !i_out_ready)

    // Every last byte that is decoded produces an end of string result.
    `U2C_ASSERT(a_last_gives_result, step && r_in.is_last |=> r_out_valid && r_out.end_of_string)

    // After the last byte the sequence state is back at its reset values.
    `U2C_ASSERT(a_last_clears_state, step && r_in.is_last |=> core_st == {2'd0, u2c_pkg::SEEN_ONE})

endmodule

`default_nettype wire
